>>> design/rbm_pkg.sv
package rbm_pkg;

  localparam int CH_W      = 24;
  localparam int FLAG_W    = 32;
  localparam int BR_W      = 41;
  localparam int CR_STEPS  = 24;
  localparam int DIV_STEPS = 24;
  // input reg, mag, sum, partials, cube init + steps, select, mult, num,
  // divider init + steps, output reg
  localparam int NST = 4 + (CR_STEPS + 1) + 3 + (DIV_STEPS + 1) + 1;

  localparam int ILLEGAL_BIT = 0;
  localparam logic [FLAG_W-1:0] ILLEGAL_MASK = 32'h01010101 << ILLEGAL_BIT;

  localparam logic [1:0] MODE_Y     = 2'd0;
  localparam logic [1:0] MODE_SUM   = 2'd1;
  localparam logic [1:0] MODE_GEO   = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // srgb y weights in q16, sum 65536; red in the lowest slot
  localparam logic [2:0][16:0] W_Y = {17'd4732, 17'd46871, 17'd13933};

  typedef struct packed {
    logic [2:0][CH_W-1:0] ch;
    logic [FLAG_W-1:0]    flags;
  } ctx_t;

  typedef struct packed {
    logic [71:0] op;
    logic [51:0] rem;
    logic [23:0] y;
    logic [47:0] y2;
  } cst_t;

  typedef struct packed {
    ctx_t                 ctx;
    logic [1:0][BR_W-1:0] bl;
    logic [1:0]           gz;
    logic [1:0]           godd;
    cst_t [1:0]           cs;
  } cr_t;

  typedef struct packed {
    logic [38:0] rem;
    logic [23:0] low;
    logic [23:0] q;
    logic        sat;
    logic        neg;
  } dch_t;

  typedef struct packed {
    dch_t [2:0]        c;
    logic              ok;
    logic [38:0]       d;
    logic [FLAG_W-1:0] flags;
  } dv_t;

  // one binary digit of the cube root, three operand bits in
  function automatic cst_t cube_step(cst_t s);
    cst_t        r;
    logic [51:0] rem8;
    logic [51:0] test;
    rem8 = {s.rem[48:0], s.op[71:69]};
    test = ({4'b0, s.y2} << 3) + ({4'b0, s.y2} << 2) + ({28'b0, s.y} << 2)
         + ({28'b0, s.y} << 1) + 52'd1;
    r.op = s.op << 3;
    if (rem8 >= test) begin
      r.rem = rem8 - test;
      r.y   = {s.y[22:0], 1'b1};
      r.y2  = {s.y2[45:0], 2'b00} + {22'b0, s.y, 2'b00} + 48'd1;
    end else begin
      r.rem = rem8;
      r.y   = {s.y[22:0], 1'b0};
      r.y2  = {s.y2[45:0], 2'b00};
    end
    return r;
  endfunction

  // one restoring division step
  function automatic dch_t div_step(dch_t s, logic [38:0] d);
    dch_t        r;
    logic [39:0] rem2;
    rem2  = {s.rem, s.low[23]};
    r     = s;
    r.low = {s.low[22:0], 1'b0};
    if (rem2 >= {1'b0, d}) begin
      r.rem = 39'(rem2 - {1'b0, d});
      r.q   = {s.q[22:0], 1'b1};
    end else begin
      r.rem = rem2[38:0];
      r.q   = {s.q[22:0], 1'b0};
    end
    return r;
  endfunction

endpackage

>>> design/rgb_brightness_match_unit.sv
// Brightness match of one pixel pair per beat: the input rgb is scaled by
// reference brightness over input brightness (srgb y, channel sum or cube-root
// geometric mean, chosen by the mode register), rounded half away from zero and
// saturated to signed 24-bit q8. Where the ratio is not defined the rgb is zero
// and the illegal-operation bit is set in every flag byte; the two flag words
// are always ored. One beat is taken per cycle while the pipeline is not held;
// there are 58 register stages, which hold the 24-step cube-root pipeline and
// the 24-step divider pipeline. The whole pipeline holds while a result waits
// on out_tready. Write the mode only while the pipeline is empty.
module rgb_brightness_match_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_data,   // brightness_mode
  input  logic         in_tvalid,
  output logic         in_tready,
  // in_red, in_green, in_blue, ref_red, ref_green, ref_blue, in_flags, ref_flags
  input  logic [207:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_red, out_green, out_blue, out_flags
  output logic [103:0] out_tdata
);

  localparam int NST = rbm_pkg::NST;
  localparam int CRS = rbm_pkg::CR_STEPS;
  localparam int DVS = rbm_pkg::DIV_STEPS;

  logic             ce;
  logic [1:0]       mode_r;
  logic [NST-1:0]   v_r, v_nxt;

  // stage 0: captured beat
  logic [5:0][23:0] a_ch_r, a_ch_nxt;
  logic [31:0]      a_flags_r, a_flags_nxt;
  // stage 1: magnitudes and weighted terms
  rbm_pkg::ctx_t    b_ctx_r, b_ctx_nxt;
  logic [5:0][40:0] b_wp_r, b_wp_nxt;
  logic [5:0][23:0] b_mag_r, b_mag_nxt;
  logic [1:0]       b_gz_r, b_gz_nxt, b_godd_r, b_godd_nxt;
  // stage 2: linear brightness and first product
  rbm_pkg::ctx_t    c_ctx_r, c_ctx_nxt;
  logic [1:0][40:0] c_bl_r, c_bl_nxt;
  logic [1:0][47:0] c_ab_r, c_ab_nxt;
  logic [1:0][23:0] c_c_r, c_c_nxt;
  logic [1:0]       c_gz_r, c_gz_nxt, c_godd_r, c_godd_nxt;
  // stage 3: partial products of the triple product
  rbm_pkg::ctx_t    d_ctx_r, d_ctx_nxt;
  logic [1:0][40:0] d_bl_r, d_bl_nxt;
  logic [1:0][47:0] d_hi_r, d_hi_nxt, d_lo_r, d_lo_nxt;
  logic [1:0]       d_gz_r, d_gz_nxt, d_godd_r, d_godd_nxt;
  // cube-root pipeline
  rbm_pkg::cr_t     cr_r [0:CRS];
  rbm_pkg::cr_t     cr_nxt [0:CRS];
  // select stage
  logic [31:0]      s_flags_r, s_flags_nxt;
  logic             s_ok_r, s_ok_nxt;
  logic [38:0]      s_d_r, s_d_nxt, s_bref_r, s_bref_nxt;
  logic [2:0][23:0] s_mag_r, s_mag_nxt;
  logic [2:0]       s_neg_r, s_neg_nxt;
  // scale multiply
  logic [31:0]      m_flags_r, m_flags_nxt;
  logic             m_ok_r, m_ok_nxt;
  logic [38:0]      m_d_r, m_d_nxt;
  logic [2:0][43:0] m_lo_r, m_lo_nxt;
  logic [2:0][42:0] m_hi_r, m_hi_nxt;
  logic [2:0]       m_neg_r, m_neg_nxt;
  // rounded numerator
  logic [31:0]      n_flags_r, n_flags_nxt;
  logic             n_ok_r, n_ok_nxt;
  logic [38:0]      n_d_r, n_d_nxt;
  logic [2:0][63:0] n_num_r, n_num_nxt;
  logic [2:0]       n_neg_r, n_neg_nxt;
  // divider pipeline
  rbm_pkg::dv_t     dv_r [0:DVS];
  rbm_pkg::dv_t     dv_nxt [0:DVS];
  // output register
  logic [2:0][23:0] o_ch_r, o_ch_nxt;
  logic [31:0]      o_flags_r, o_flags_nxt;

  assign ce         = ~v_r[NST-1] | out_tready;
  assign in_tready  = ce;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = v_r[NST-1];
  assign out_tdata  = {o_flags_r, o_ch_r[2], o_ch_r[1], o_ch_r[0]};

  always_comb begin
    logic signed [23:0] chs;
    logic [40:0]        bsel [2];
    logic               bdef [2];
    logic [23:0]        mq;
    logic [23:0]        dn;
    v_nxt = {v_r[NST-2:0], in_tvalid};

    for (int k = 0; k < 6; k++) begin
      a_ch_nxt[k] = in_tdata[k*24 +: 24];
    end
    a_flags_nxt = in_tdata[175:144] | in_tdata[207:176];

    // stage 1
    b_ctx_nxt.ch    = a_ch_r[2:0];
    b_ctx_nxt.flags = a_flags_r;
    for (int k = 0; k < 6; k++) begin
      chs = signed'(a_ch_r[k]);
      if (mode_r == rbm_pkg::MODE_SUM) begin
        b_wp_nxt[k] = 41'(chs);
      end else begin
        b_wp_nxt[k] = 41'(chs * signed'(rbm_pkg::W_Y[k % 3]));
      end
      b_mag_nxt[k] = a_ch_r[k][23] ? 24'(-a_ch_r[k]) : a_ch_r[k];
    end
    for (int p = 0; p < 2; p++) begin
      b_gz_nxt[p]   = (a_ch_r[3*p] == '0) | (a_ch_r[3*p+1] == '0) | (a_ch_r[3*p+2] == '0);
      b_godd_nxt[p] = a_ch_r[3*p][23] ^ a_ch_r[3*p+1][23] ^ a_ch_r[3*p+2][23];
    end

    // stage 2
    c_ctx_nxt  = b_ctx_r;
    c_gz_nxt   = b_gz_r;
    c_godd_nxt = b_godd_r;
    for (int p = 0; p < 2; p++) begin
      c_bl_nxt[p] = b_wp_r[3*p] + b_wp_r[3*p+1] + b_wp_r[3*p+2];
      c_ab_nxt[p] = 48'(b_mag_r[3*p]) * 48'(b_mag_r[3*p+1]);
      c_c_nxt[p]  = b_mag_r[3*p+2];
    end

    // stage 3: 48 x 24 split in two 24 x 24 halves
    d_ctx_nxt  = c_ctx_r;
    d_bl_nxt   = c_bl_r;
    d_gz_nxt   = c_gz_r;
    d_godd_nxt = c_godd_r;
    for (int p = 0; p < 2; p++) begin
      d_hi_nxt[p] = 48'(c_ab_r[p][47:24]) * 48'(c_c_r[p]);
      d_lo_nxt[p] = 48'(c_ab_r[p][23:0]) * 48'(c_c_r[p]);
    end

    // cube-root init and steps
    cr_nxt[0].ctx  = d_ctx_r;
    cr_nxt[0].bl   = d_bl_r;
    cr_nxt[0].gz   = d_gz_r;
    cr_nxt[0].godd = d_godd_r;
    for (int p = 0; p < 2; p++) begin
      cr_nxt[0].cs[p].op  = {d_hi_r[p], 24'b0} + {24'b0, d_lo_r[p]};
      cr_nxt[0].cs[p].rem = '0;
      cr_nxt[0].cs[p].y   = '0;
      cr_nxt[0].cs[p].y2  = '0;
    end
    for (int i = 1; i <= CRS; i++) begin
      cr_nxt[i] = cr_r[i-1];
      for (int p = 0; p < 2; p++) begin
        cr_nxt[i].cs[p] = rbm_pkg::cube_step(cr_r[i-1].cs[p]);
      end
    end

    // brightness select and ratio check
    for (int p = 0; p < 2; p++) begin
      if (mode_r == rbm_pkg::MODE_GEO) begin
        bsel[p] = cr_r[CRS].gz[p] ? '0 : {17'b0, cr_r[CRS].cs[p].y};
        bdef[p] = cr_r[CRS].gz[p] | ~cr_r[CRS].godd[p];
      end else begin
        bsel[p] = cr_r[CRS].bl[p];
        bdef[p] = 1'b1;
      end
    end
    s_flags_nxt = cr_r[CRS].ctx.flags;
    s_ok_nxt    = bdef[0] & bdef[1] & ~bsel[0][40] & (bsel[0] != '0) & ~bsel[1][40];
    s_d_nxt     = bsel[0][38:0];
    s_bref_nxt  = bsel[1][38:0];
    for (int k = 0; k < 3; k++) begin
      s_neg_nxt[k] = cr_r[CRS].ctx.ch[k][23];
      s_mag_nxt[k] = s_neg_nxt[k] ? 24'(-cr_r[CRS].ctx.ch[k]) : cr_r[CRS].ctx.ch[k];
    end

    // channel times reference brightness, two halves
    m_flags_nxt = s_flags_r;
    m_ok_nxt    = s_ok_r;
    m_d_nxt     = s_d_r;
    m_neg_nxt   = s_neg_r;
    for (int k = 0; k < 3; k++) begin
      m_lo_nxt[k] = 44'(s_mag_r[k]) * 44'(s_bref_r[19:0]);
      m_hi_nxt[k] = 43'(s_mag_r[k]) * 43'(s_bref_r[38:20]);
    end

    // numerator plus half divisor
    n_flags_nxt = m_flags_r;
    n_ok_nxt    = m_ok_r;
    n_d_nxt     = m_d_r;
    n_neg_nxt   = m_neg_r;
    for (int k = 0; k < 3; k++) begin
      n_num_nxt[k] = {1'b0, m_hi_r[k], 20'b0} + {20'b0, m_lo_r[k]} + {26'b0, m_d_r[38:1]};
    end

    // divider init: quotient of 2^24 or more saturates
    dv_nxt[0].ok    = n_ok_r;
    dv_nxt[0].d     = n_d_r;
    dv_nxt[0].flags = n_flags_r;
    for (int k = 0; k < 3; k++) begin
      dv_nxt[0].c[k].sat = n_num_r[k][63:24] >= {1'b0, n_d_r};
      dv_nxt[0].c[k].rem = n_num_r[k][62:24];
      dv_nxt[0].c[k].low = n_num_r[k][23:0];
      dv_nxt[0].c[k].q   = '0;
      dv_nxt[0].c[k].neg = n_neg_r[k];
    end
    for (int i = 1; i <= DVS; i++) begin
      dv_nxt[i] = dv_r[i-1];
      for (int k = 0; k < 3; k++) begin
        dv_nxt[i].c[k] = rbm_pkg::div_step(dv_r[i-1].c[k], dv_r[i-1].d);
      end
    end

    // sign, saturation and invalid result
    for (int k = 0; k < 3; k++) begin
      mq = dv_r[DVS].c[k].q;
      dn = 24'(-mq);
      if (!dv_r[DVS].ok) begin
        o_ch_nxt[k] = '0;
      end else if (dv_r[DVS].c[k].neg) begin
        o_ch_nxt[k] = (dv_r[DVS].c[k].sat | (mq > 24'h800000)) ? 24'h800000 : dn;
      end else begin
        o_ch_nxt[k] = (dv_r[DVS].c[k].sat | mq[23]) ? 24'h7fffff : mq;
      end
    end
    o_flags_nxt = dv_r[DVS].ok ? dv_r[DVS].flags
                               : (dv_r[DVS].flags | rbm_pkg::ILLEGAL_MASK);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= rbm_pkg::MODE_Y;
      v_r    <= '0;
    end else begin
      if (cfg_valid) begin
        mode_r <= cfg_data;
      end
      if (ce) begin
        v_r <= v_nxt;
      end
    end
    // payload, no reset
    if (ce) begin
      a_ch_r    <= a_ch_nxt;
      a_flags_r <= a_flags_nxt;
      b_ctx_r   <= b_ctx_nxt;
      b_wp_r    <= b_wp_nxt;
      b_mag_r   <= b_mag_nxt;
      b_gz_r    <= b_gz_nxt;
      b_godd_r  <= b_godd_nxt;
      c_ctx_r   <= c_ctx_nxt;
      c_bl_r    <= c_bl_nxt;
      c_ab_r    <= c_ab_nxt;
      c_c_r     <= c_c_nxt;
      c_gz_r    <= c_gz_nxt;
      c_godd_r  <= c_godd_nxt;
      d_ctx_r   <= d_ctx_nxt;
      d_bl_r    <= d_bl_nxt;
      d_hi_r    <= d_hi_nxt;
      d_lo_r    <= d_lo_nxt;
      d_gz_r    <= d_gz_nxt;
      d_godd_r  <= d_godd_nxt;
      for (int i = 0; i <= CRS; i++) begin
        cr_r[i] <= cr_nxt[i];
      end
      s_flags_r <= s_flags_nxt;
      s_ok_r    <= s_ok_nxt;
      s_d_r     <= s_d_nxt;
      s_bref_r  <= s_bref_nxt;
      s_mag_r   <= s_mag_nxt;
      s_neg_r   <= s_neg_nxt;
      m_flags_r <= m_flags_nxt;
      m_ok_r    <= m_ok_nxt;
      m_d_r     <= m_d_nxt;
      m_lo_r    <= m_lo_nxt;
      m_hi_r    <= m_hi_nxt;
      m_neg_r   <= m_neg_nxt;
      n_flags_r <= n_flags_nxt;
      n_ok_r    <= n_ok_nxt;
      n_d_r     <= n_d_nxt;
      n_num_r   <= n_num_nxt;
      n_neg_r   <= n_neg_nxt;
      for (int i = 0; i <= DVS; i++) begin
        dv_r[i] <= dv_nxt[i];
      end
      o_ch_r    <= o_ch_nxt;
      o_flags_r <= o_flags_nxt;
    end
  end

endmodule

>>> tb/rgb_brightness_match_unit_tb.sv
`timescale 1ns / 100ps

module rgb_brightness_match_unit_tb;

  // one pixel pair as it goes into the block
  typedef struct {
    logic signed [rbm_pkg::CH_W-1:0] in_r, in_g, in_b;
    logic signed [rbm_pkg::CH_W-1:0] ref_r, ref_g, ref_b;
    logic [rbm_pkg::FLAG_W-1:0]      in_f, ref_f;
  } pix_pair_t;

  // one matched pixel as it comes out
  typedef struct {
    logic [rbm_pkg::CH_W-1:0]   r, g, b;
    logic [rbm_pkg::FLAG_W-1:0] f;
  } matched_t;

  localparam int LATENCY    = 58;
  localparam int HOLD_LEN   = 400;
  localparam int CYCLE_CAP  = 400000;
  localparam int N_RANDOM   = 190;

  logic         clk;
  logic         rst_n;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_data;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [207:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;

  pix_pair_t pending_pix[$];   // pixels waiting to be offered
  matched_t  matched_q[$];     // predicted results, oldest first
  pix_pair_t offered_pix;      // pixel on the bus right now
  logic [1:0] model_mode;      // predictor copy of the brightness mode
  int send_idle_pct;
  int recv_idle_pct;
  int hold_reqs;
  int hold_seen = 0;
  int hold_left = 0;
  int mismatches = 0;
  int n_pixels = 0;
  int n_matched = 0;
  int cycles = 0;

  rgb_brightness_match_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // floor of the cube root of a*b*c, one result bit at a time
  function automatic longint cube_root_floor(logic [23:0] a, logic [23:0] b, logic [23:0] c);
    logic [79:0] prod;
    logic [79:0] t3;
    logic [23:0] y;
    logic [23:0] t;
    prod = 80'(a) * 80'(b) * 80'(c);
    y = '0;
    for (int bt = 23; bt >= 0; bt--) begin
      t  = y | (24'd1 << bt);
      t3 = 80'(t) * 80'(t) * 80'(t);
      if (t3 <= prod) y = t;
    end
    return longint'(y);
  endfunction

  function automatic logic [23:0] mag24(longint v);
    return (v < 0) ? 24'(-v) : 24'(v);
  endfunction

  // brightness of one pixel; returns 0 where the measure is undefined
  function automatic bit pixel_brightness(logic [1:0] mode, longint r, longint g, longint b,
                                          output longint br);
    int negs;
    br = 0;
    case (mode)
      rbm_pkg::MODE_SUM: begin
        br = r + g + b;
      end
      rbm_pkg::MODE_GEO: begin
        negs = (r < 0) + (g < 0) + (b < 0);
        if (r == 0 || g == 0 || b == 0) return 1'b1;
        if (negs % 2 == 1) return 1'b0;
        br = cube_root_floor(mag24(r), mag24(g), mag24(b));
      end
      default: begin
        // the spare mode value measures as srgb y
        br = 13933 * r + 46871 * g + 4732 * b;
      end
    endcase
    return 1'b1;
  endfunction

  // channel times ref brightness over input brightness, half away from zero, saturated
  function automatic logic [rbm_pkg::CH_W-1:0] scale_channel(longint ch, longint bref,
                                                             longint bin);
    logic signed [95:0] num;
    logic [95:0]        m;
    logic [95:0]        q;
    num = 96'(ch) * 96'(bref);
    m   = (num < 0) ? 96'(-num) : 96'(num);
    q   = (m + 96'(bin / 2)) / 96'(bin);
    if (num < 0) return (q > 96'd8388608) ? 24'h800000 : 24'(-q);
    return (q > 96'd8388607) ? 24'h7fffff : 24'(q);
  endfunction

  function automatic matched_t predict_pixel(pix_pair_t p, logic [1:0] mode);
    matched_t res;
    longint   bin, bref;
    bit       din, dref;
    din  = pixel_brightness(mode, p.in_r, p.in_g, p.in_b, bin);
    dref = pixel_brightness(mode, p.ref_r, p.ref_g, p.ref_b, bref);
    res.f = p.in_f | p.ref_f;
    if (din && dref && bin > 0 && bref >= 0) begin
      res.r = scale_channel(p.in_r, bref, bin);
      res.g = scale_channel(p.in_g, bref, bin);
      res.b = scale_channel(p.in_b, bref, bin);
    end else begin
      res.r = '0;
      res.g = '0;
      res.b = '0;
      res.f = res.f | rbm_pkg::ILLEGAL_MASK;
    end
    return res;
  endfunction

  function automatic logic [207:0] pack_pixels(pix_pair_t p);
    return {p.ref_f, p.in_f, p.ref_b, p.ref_g, p.ref_r, p.in_b, p.in_g, p.in_r};
  endfunction

  // random channel with weight on zero, the extremes and small magnitudes
  function automatic logic signed [rbm_pkg::CH_W-1:0] rand_channel();
    case ($urandom_range(9))
      0: return '0;
      1: return 24'sh7fffff;
      2: return 24'sh800000;
      3: return 24'($urandom_range(1, 4096));
      4: return -24'($urandom_range(1, 1 << 16));
      5: return 24'($urandom);
      default: return 24'($urandom_range(1, 1 << 20));
    endcase
  endfunction

  function automatic logic [rbm_pkg::FLAG_W-1:0] rand_flags();
    return ($urandom_range(9) < 4) ? '0 : $urandom;
  endfunction

  function automatic pix_pair_t make_pair(int ir, int ig, int ib, int rr, int rg, int rb);
    pix_pair_t p;
    p.in_r  = 24'(ir);
    p.in_g  = 24'(ig);
    p.in_b  = 24'(ib);
    p.ref_r = 24'(rr);
    p.ref_g = 24'(rg);
    p.ref_b = 24'(rb);
    p.in_f  = rand_flags();
    p.ref_f = rand_flags();
    return p;
  endfunction

  // extremes and the undefined-ratio cases
  task automatic queue_directed();
    pix_pair_t p;
    pending_pix.push_back(make_pair(256, 256, 256, 512, 512, 512));
    pending_pix.push_back(make_pair(8388607, 8388607, 8388607, 8388607, 8388607, 8388607));
    pending_pix.push_back(make_pair(-8388608, -8388608, -8388608, 256, 256, 256));
    // tiny input, huge reference
    pending_pix.push_back(make_pair(1, 1, 1, 8388607, 8388607, 8388607));
    pending_pix.push_back(make_pair(1, -8388608, 1, 8388607, 8388607, 8388607));
    // zero input brightness
    pending_pix.push_back(make_pair(0, 0, 0, 256, 256, 256));
    // negative reference brightness
    pending_pix.push_back(make_pair(256, 256, 256, -256, -256, -256));
    // zero reference brightness is legal
    pending_pix.push_back(make_pair(300, 400, 500, 0, 0, 0));
    // odd count of negatives: undefined geometric mean
    pending_pix.push_back(make_pair(-256, 256, 256, 256, 256, 256));
    pending_pix.push_back(make_pair(256, 256, 256, -256, 256, 256));
    // even count of negatives: defined
    pending_pix.push_back(make_pair(-256, -256, 256, 256, -256, -256));
    // one zero channel gives a zero geometric mean
    pending_pix.push_back(make_pair(256, 0, 256, 256, 256, 256));
    pending_pix.push_back(make_pair(256, 256, 256, 0, 256, 256));
    // smallest cube root and the rounding tie
    pending_pix.push_back(make_pair(1, 1, 1, 1, 1, 1));
    pending_pix.push_back(make_pair(3, 1, 2, 1, 1, 1));
    pending_pix.push_back(make_pair(-3, 5, 2, 1, 2, 0));
    pending_pix.push_back(make_pair(8388607, -8388608, 1, 1, 1, 1));
    p = make_pair(1000, 2000, 3000, 3000, 2000, 1000);
    p.in_f  = 32'hffffffff;
    p.ref_f = 32'h0;
    pending_pix.push_back(p);
    p.in_f  = 32'h0;
    p.ref_f = 32'hffffffff;
    pending_pix.push_back(p);
  endtask

  // mostly well-formed positive pixel pairs, the rest noise
  task automatic queue_random(int n);
    pix_pair_t p;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 75) begin
        p = make_pair($urandom_range(1, 1 << 20), $urandom_range(1, 1 << 20),
                      $urandom_range(1, 1 << 20), $urandom_range(0, 1 << 22),
                      $urandom_range(0, 1 << 22), $urandom_range(0, 1 << 22));
      end else begin
        p.in_r  = rand_channel();
        p.in_g  = rand_channel();
        p.in_b  = rand_channel();
        p.ref_r = rand_channel();
        p.ref_g = rand_channel();
        p.ref_b = rand_channel();
        p.in_f  = rand_flags();
        p.ref_f = rand_flags();
      end
      pending_pix.push_back(p);
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s at result %0d: got %h want %h", what, n_matched, got, want);
    mismatches++;
  endtask

  // everything sent and drained, then let the pipeline settle
  task automatic wait_drained();
    while (pending_pix.size() != 0 || in_tvalid || matched_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_mode(logic [1:0] mode);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (!cfg_ready);
    model_mode = mode;
    cfg_valid <= 1'b0;
  endtask

  // driver: offers queued pixels, predicts at each accepted beat
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        matched_q.push_back(predict_pixel(offered_pix, model_mode));
        n_pixels++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_pix.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered_pix = pending_pix.pop_front();
          in_tdata  <= pack_pixels(offered_pix);
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_LEN;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: checks each accepted result beat against the oldest prediction
  always @(posedge clk) begin
    matched_t got;
    matched_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.r = out_tdata[23:0];
        got.g = out_tdata[47:24];
        got.b = out_tdata[71:48];
        got.f = out_tdata[103:72];
        if (matched_q.size() == 0) begin
          report_mismatch("unexpected beat", got.f, '0);
        end else begin
          want = matched_q.pop_front();
          if (got.r !== want.r) report_mismatch("red", 32'(got.r), 32'(want.r));
          if (got.g !== want.g) report_mismatch("green", 32'(got.g), 32'(want.g));
          if (got.b !== want.b) report_mismatch("blue", 32'(got.b), 32'(want.b));
          if (got.f !== want.f) report_mismatch("flags", got.f, want.f);
        end
        n_matched++;
      end
      out_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, matched_q.size());
      $display("[rgb_brightness_match_unit] ERROR");
      $finish;
    end
  end

  initial begin
    logic [1:0] modes [6];
    modes = '{rbm_pkg::MODE_Y, rbm_pkg::MODE_GEO, rbm_pkg::MODE_SUM, rbm_pkg::MODE_SPARE,
              rbm_pkg::MODE_GEO, rbm_pkg::MODE_Y};
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    model_mode = rbm_pkg::MODE_Y;
    send_idle_pct = 26;
    recv_idle_pct = 62;
    hold_reqs = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 6; ph++) begin
      // idling regime: sender light, then receiver light, then none
      if (ph < 2) begin
        send_idle_pct = 26;
        recv_idle_pct = 62;
      end else if (ph < 4) begin
        send_idle_pct = 62;
        recv_idle_pct = 26;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_mode(modes[ph]);
      queue_directed();
      queue_random(N_RANDOM);
      // receiver stalls long while the sender keeps going: pipeline fills
      if (ph == 0 || ph == 4) hold_reqs++;
      // sender pauses here until every result is back
      wait_drained();
    end

    $display("checked %0d pixel pairs, %0d results, over brightness modes y, sum, geo and spare",
             n_pixels, n_matched);
    $display("with sender and receiver idling, long output stalls and drained pauses");
    if (mismatches == 0) begin
      $display("[rgb_brightness_match_unit] OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[rgb_brightness_match_unit] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
design/rbm_pkg.sv
design/rgb_brightness_match_unit.sv
tb/rgb_brightness_match_unit_tb.sv
